>>> rtl/dq_pkg.sv
// Shared types and constants of the double-ended queue.
package dq_pkg;

  localparam int DQ_DEPTH      = 16;
  localparam int DQ_CMDQ_DEPTH = 2;
  localparam int DQ_VALUE_W    = 32;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_REAR   = 3'd3;
  localparam logic [2:0] MODE_LIST       = 3'd4;

  typedef logic signed [DQ_VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_LIST
  } op_t;

  typedef struct packed {
    op_t    op;
    value_t value;
  } cmd_t;

endpackage

>>> rtl/dq_in_if.sv
// Input channel of the double-ended queue: operation mode and value.
interface dq_in_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           mode;
  dq_pkg::value_t       value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

>>> rtl/dq_out_if.sv
// Result channel of the double-ended queue: value, status and last marker.
interface dq_out_if;
  logic                 valid;
  logic                 ready;
  dq_pkg::value_t       value_res;
  dq_pkg::status_t      status;
  logic                 last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

>>> rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values held in a ring buffer.
// Each transfer on in_ch carries a mode and a value: push front, push rear,
// pop front, pop rear or list all; unused modes are taken and dropped.
// Results leave on out_ch as value_res, status and last; last marks the
// final result of an item. A push gives one result (value echoed, or status
// full); a pop gives the removed value or status empty; a list gives every
// held value from front to rear, or one empty result.
// A push result, or the empty result of a pop or list, passes the command queue
// and the result register; a pop result and the first list result also pass
// the registered storage read. A push or an operation on an empty queue is
// done in the back end's idle state; a pop or list also passes its data state,
// where it takes no new command, and a list reads its next entry while the
// current one is sent.
// A two-entry command queue between the decoder and the storage side keeps
// in_ch.ready high while the back end works; in_ch stalls once it is full.
// When out_ch.ready is low the result register holds its transfer and the
// back end waits; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the queue and drops pending work;
// storage contents are not cleared and are never read before being written.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  dq_in_if.sink     in_ch,
  dq_out_if.source  out_ch
);
  import dq_pkg::*;

  logic  cmd_valid;
  logic  cmd_ready;
  cmd_t  cmd;

  dq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/dq_front.sv
// Front end: accepts items, decodes the mode and queues commands for the back end.
module dq_front (
  input  logic          clk,
  input  logic          rst_n,
  dq_in_if.sink         in_ch,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output dq_pkg::cmd_t  cmd
);
  import dq_pkg::*;

  localparam int QDEPTH = DQ_CMDQ_DEPTH;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  logic  in_xfer;
  logic  known;
  op_t   op;
  logic  push;
  logic  pop;

  // Unused mode codes are taken and dropped; they cause no result.
  always_comb begin
    known = 1'b1;
    op    = OP_LIST;
    unique case (in_ch.mode)
      MODE_PUSH_FRONT: op = OP_PUSH_FRONT;
      MODE_PUSH_REAR:  op = OP_PUSH_REAR;
      MODE_POP_FRONT:  op = OP_POP_FRONT;
      MODE_POP_REAR:   op = OP_POP_REAR;
      MODE_LIST:       op = OP_LIST;
      default:         known = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_r != QCW'(QDEPTH));
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign push        = in_xfer && known;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op, value: in_ch.value};
    end
  end

endmodule

>>> rtl/dq_back.sv
// Back end: ring buffer storage, head and fill tracking, and the result register.
module dq_back #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  dq_pkg::cmd_t  cmd,
  dq_out_if.source      out_ch
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic {S_IDLE, S_DATA} state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic           out_valid_r, out_valid_nxt;
  value_t         out_value_r, out_value_nxt;
  status_t        out_status_r, out_status_nxt;
  logic           out_last_r, out_last_nxt;

  value_t         mem [DEPTH];
  value_t         rd_data_r;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;

  logic           out_free;
  logic           full;
  logic           empty;

  // Position offset entries past base, wrapped once around the ring.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    cmd_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_value_nxt  = '0;
                out_status_nxt = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_value_nxt  = cmd.value;
                out_status_nxt = ST_OK;
                if (cmd.op == OP_PUSH_FRONT) begin
                  wr_addr  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
                  head_nxt = wr_addr;
                end else begin
                  wr_addr = slot(head_r, count_r);
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_LIST: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = ST_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DATA;
                rem_nxt   = '0;
                if (cmd.op == OP_POP_FRONT) begin
                  rd_addr   = head_r;
                  head_nxt  = inc(head_r);
                  count_nxt = count_r - 1'b1;
                end else if (cmd.op == OP_POP_REAR) begin
                  rd_addr   = slot(head_r, count_r - 1'b1);
                  count_nxt = count_r - 1'b1;
                end else begin
                  rd_addr = head_r;
                  pos_nxt = inc(head_r);
                  rem_nxt = count_r - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DATA: begin
        // Read data is ready; a list reads its next entry while this one is sent.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = (rem_r == '0);
          if (rem_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_r;
            pos_nxt = inc(pos_r);
            rem_nxt = rem_r - 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    rem_r        <= rem_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

endmodule

>>> dv/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: directed table, then random traffic.
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH = DQ_DEPTH;
  localparam int RANDOM_ITEMS = 350;
  localparam int PHASE_ITEMS = 38;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT = 2_000_000;

  // Modes outside the defined set; the block takes and drops them.
  localparam logic [2:0] MODE_RSVD_5 = 3'd5;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  typedef struct {
    value_t  val;
    status_t st;
    logic    last;
  } dq_result_t;

  typedef struct {
    logic [2:0] mode;
    value_t     value;
    int         reps;
    bit         typed;
    value_t     tval;
    status_t    tst;
  } stim_row_t;

  // Rows marked typed carry their single result in the last two columns.
  stim_row_t directed_rows [15] = '{
    '{MODE_POP_FRONT,  32'sh0000_0000, 1,  1'b1, 32'sh0000_0000, ST_EMPTY},
    '{MODE_POP_REAR,   32'sh0000_0000, 1,  1'b1, 32'sh0000_0000, ST_EMPTY},
    '{MODE_LIST,       32'sh0000_0000, 1,  1'b1, 32'sh0000_0000, ST_EMPTY},
    '{MODE_PUSH_FRONT, 32'sh7fff_ffff, 1,  1'b1, 32'sh7fff_ffff, ST_OK},
    '{MODE_PUSH_REAR,  32'sh8000_0000, 1,  1'b1, 32'sh8000_0000, ST_OK},
    '{MODE_PUSH_FRONT, 32'sh0000_0000, 1,  1'b1, 32'sh0000_0000, ST_OK},
    '{MODE_PUSH_REAR,  32'shffff_ffff, 1,  1'b1, 32'shffff_ffff, ST_OK},
    '{MODE_RSVD_5,     32'sh1111_1111, 1,  1'b0, 32'sh0000_0000, ST_OK},
    '{MODE_PUSH_REAR,  32'sh5a5a_0000, 12, 1'b0, 32'sh0000_0000, ST_OK},
    '{MODE_PUSH_FRONT, 32'sh0000_1234, 1,  1'b1, 32'sh0000_0000, ST_FULL},
    '{MODE_PUSH_REAR,  32'sh0000_4321, 1,  1'b1, 32'sh0000_0000, ST_FULL},
    '{MODE_LIST,       32'sh0000_0000, 1,  1'b0, 32'sh0000_0000, ST_OK},
    '{MODE_RSVD_7,     32'sh2222_2222, 1,  1'b0, 32'sh0000_0000, ST_OK},
    '{MODE_POP_REAR,   32'sh0000_0000, 1,  1'b0, 32'sh0000_0000, ST_OK},
    '{MODE_POP_FRONT,  32'sh0000_0000, 1,  1'b0, 32'sh0000_0000, ST_OK}
  };

  logic clk = 1'b0;
  logic rst_n;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: a ring of held values, the front position and the count.
  value_t                       model_store [DEPTH];
  int                           model_head = 0;
  int                           model_fill = 0;
  dq_result_t                   model_out [$];
  dq_result_t                   results_due [$];

  int     mismatch_count = 0;
  bit     no_idle = 1'b0;
  bit     row_typed = 1'b0;
  value_t row_tval = '0;
  status_t row_tst = ST_OK;

  function automatic void deque_model_apply(input logic [2:0] md, input value_t v);
    int pos;
    model_out.delete();
    case (md)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (model_fill == DEPTH) begin
          model_out.push_back('{val: '0, st: ST_FULL, last: 1'b1});
        end else begin
          if (md == MODE_PUSH_FRONT) begin
            model_head = (int'(model_head) + DEPTH - 1) % DEPTH;
            pos = model_head;
          end else begin
            pos = (int'(model_head) + int'(model_fill)) % DEPTH;
          end
          model_store[pos] = v;
          model_fill++;
          model_out.push_back('{val: v, st: ST_OK, last: 1'b1});
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (model_fill == 0) begin
          model_out.push_back('{val: '0, st: ST_EMPTY, last: 1'b1});
        end else begin
          if (md == MODE_POP_FRONT) begin
            pos = model_head;
            model_head = (int'(model_head) + 1) % DEPTH;
          end else begin
            pos = (int'(model_head) + int'(model_fill) - 1) % DEPTH;
          end
          model_fill--;
          model_out.push_back('{val: model_store[pos], st: ST_OK, last: 1'b1});
        end
      end
      MODE_LIST: begin
        if (model_fill == 0) begin
          model_out.push_back('{val: '0, st: ST_EMPTY, last: 1'b1});
        end else begin
          for (int i = 0; i < int'(model_fill); i++) begin
            pos = (int'(model_head) + i) % DEPTH;
            model_out.push_back('{val: model_store[pos], st: ST_OK,
                                  last: (i == int'(model_fill) - 1)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [2:0] md, input value_t v);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= md;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Both transfers of a clock edge are handled here, inputs first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        deque_model_apply(in_ch.mode, in_ch.value);
        if (row_typed) begin
          results_due.push_back('{val: row_tval, st: row_tst, last: 1'b1});
        end else begin
          foreach (model_out[i]) results_due.push_back(model_out[i]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing pending: value_res %0d status %0d last %0b",
                   $time, out_ch.value_res, out_ch.status, out_ch.last);
          mismatch_count++;
        end else begin
          dq_result_t exp_res;
          exp_res = results_due.pop_front();
          if (out_ch.value_res !== exp_res.val) begin
            $display("%0t: value_res mismatch, expected %0d, actual %0d",
                     $time, exp_res.val, out_ch.value_res);
            mismatch_count++;
          end
          if (out_ch.status !== exp_res.st) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_res.st, out_ch.status);
            mismatch_count++;
          end
          if (out_ch.last !== exp_res.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, exp_res.last, out_ch.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Result side: stalls of random length; no new stall starts while no_idle is set.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall = idle_len();
      end
    end
  end

  initial begin
    int counted;
    int phase;
    int push_pct;
    int r;
    logic [2:0] md;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_PUSH_FRONT;
    in_ch.value = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        row_typed = directed_rows[i].typed;
        row_tval  = directed_rows[i].tval;
        row_tst   = directed_rows[i].tst;
        send_item(directed_rows[i].mode, value_t'(directed_rows[i].value + k));
      end
    end
    row_typed = 1'b0;

    // Phases lean toward filling, draining or a balance, so both ends are hit often.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase = counted / PHASE_ITEMS;
      no_idle = (phase % 4 == 2);
      case (phase % 3)
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      r = $urandom_range(0, 99);
      if (r < 4) begin
        md = 3'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
      end else begin
        counted++;
        if (r < 12) md = MODE_LIST;
        else if (r < 12 + push_pct * 88 / 100)
          md = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
        else
          md = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
      end
      if (md == MODE_PUSH_FRONT || md == MODE_PUSH_REAR) send_item(md, pick_value());
      else send_item(md, value_t'($urandom));
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule
